// ----- rtl/sbos_pkg.sv -----
package sbos_pkg;

    localparam int FIELD_W = 63;
    localparam int ID_W    = 16;
    localparam int ENTRY_W = 17;
    localparam int INFL_W  = 20;
    localparam int FRAC_Q  = 16;
    // Quotient bits kept by the divider; anything larger saturates.
    localparam int Q_BITS  = 18;
    // Width of a clamped slab bound, which lies in -1 .. 65537.
    localparam int T_W     = 19;

    localparam logic [ENTRY_W-1:0]  ONE_Q16   = 17'h10000;
    localparam logic signed [T_W-1:0] T_ZERO    = 19'sd0;
    localparam logic signed [T_W-1:0] T_ONE     = 19'sd65536;
    localparam logic signed [T_W-1:0] T_SAT_HI  = 19'sd65537;
    localparam logic signed [T_W-1:0] T_SAT_LO  = -19'sd1;

    localparam logic [2:0] TERM_LAST = 3'd5;
    localparam logic [1:0] AXIS_LAST = 2'd2;

    typedef enum logic [1:0] {
        CFG_SEG_START = 2'd0,
        CFG_SEG_END   = 2'd1,
        CFG_INFLATION = 2'd2,
        CFG_SKIP_ID   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [ID_W-1:0]    box_id;
        logic [FIELD_W-1:0] box_center;
        logic [FIELD_W-1:0] axis_one;
        logic [FIELD_W-1:0] axis_two;
        logic [FIELD_W-1:0] axis_three;
        logic [FIELD_W-1:0] half_size;
        logic               last_box;
    } t_box;

    typedef struct packed {
        logic               blocked;
        logic [ID_W-1:0]    blocker_id;
        logic [ENTRY_W-1:0] entry_param;
    } t_result;

    typedef struct packed {
        logic       mul;
        logic       acc_clr;
        logic [2:0] term;
        logic [1:0] axis;
        logic       div_start;
        logic       div_hi;
        logic       par_chk;
        logic       slab_upd;
        logic       commit;
        logic       emit;
    } t_dp_cmd;

    typedef struct packed {
        logic dir_zero;
        logic div_done;
        logic last;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- rtl/sbos_div.sv -----
module sbos_div import sbos_pkg::*; #(
    parameter int NUM_W = 46,
    parameter int DEN_W = 45
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [T_W-1:0]   o_t
);

    localparam int NMAG_W = NUM_W + FRAC_Q;
    localparam int DIV_W  = ((NMAG_W > DEN_W + Q_BITS) ? NMAG_W : DEN_W + Q_BITS) + 1;
    localparam int CNT_W  = $clog2(Q_BITS + 1);

    logic                  r_busy;
    logic                  r_first;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIV_W-1:0]      r_rem;
    logic [DIV_W-1:0]      r_dsh;
    logic [Q_BITS-1:0]     r_q;
    logic                  r_neg;
    logic                  r_done;
    logic signed [T_W-1:0] r_t;

    logic [NUM_W-1:0]      w_nmag;
    logic [DEN_W-1:0]      w_dmag;
    logic                  w_ge;
    logic [DIV_W-1:0]      n_rem;
    logic [Q_BITS-1:0]     n_q;
    logic [T_W-1:0]        w_m;
    logic signed [T_W-1:0] w_res;

    always_comb begin
        w_nmag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        w_dmag = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
        w_ge   = (r_rem >= r_dsh);
        n_rem  = w_ge ? (r_rem - r_dsh) : r_rem;
        n_q    = {r_q[Q_BITS-2:0], w_ge};
        // Floor of a negative quotient rounds away from zero on a remainder.
        w_m    = T_W'(n_q) + T_W'(n_rem != '0);
        if (!r_neg) begin
            w_res = (T_W'(n_q) > T_W'(T_SAT_HI)) ? T_SAT_HI : $signed(T_W'(n_q));
        end else begin
            w_res = (w_m > T_W'(1)) ? T_SAT_LO : $signed(-w_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_first <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_first <= 1'b1;
                r_cnt   <= CNT_W'(Q_BITS);
                r_q     <= '0;
                r_neg   <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
                r_rem   <= DIV_W'({w_nmag, {FRAC_Q{1'b0}}});
                r_dsh   <= DIV_W'({w_dmag, {(Q_BITS-1){1'b0}}});
            end else if (r_busy && r_first) begin
                r_first <= 1'b0;
                if (r_rem >= {r_dsh[DIV_W-2:0], 1'b0}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_t    <= r_neg ? T_SAT_LO : T_SAT_HI;
                end
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= n_q;
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_t    <= w_res;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_t    = r_t;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |=> !r_done)
        else $error("divider done lasted more than one cycle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_start |-> !r_busy)
        else $error("divider started while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_t >= T_SAT_LO && r_t <= T_SAT_HI))
        else $error("divider result outside clamp range");

endmodule

// ----- rtl/sbos_dp.sv -----
module sbos_dp import sbos_pkg::*; #(
    parameter int ID_BITS    = 16,
    parameter int COORD_BITS = 21
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  t_box               i_box,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [FIELD_W-1:0] i_cfg_data,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    output logic               o_res_valid,
    input  logic               i_res_stall,
    output t_result            o_res
);

    localparam int C      = COORD_BITS;
    localparam int DIFF_W = C + 1;
    localparam int PROD_W = DIFF_W + C;
    localparam int DOT_W  = PROD_W + 2;
    localparam int HEXT_W = ((C > INFL_W) ? C : INFL_W) + 1;
    localparam int EXTS_W = HEXT_W + C - 2;
    localparam int NUM_W  = ((EXTS_W + 1 > DOT_W) ? EXTS_W + 1 : DOT_W) + 1;

    logic [FIELD_W-1:0]      r_start;
    logic [FIELD_W-1:0]      r_end;
    logic [INFL_W-1:0]       r_infl;
    logic [ID_W-1:0]         r_skip;
    t_box                    r_item;

    logic                    r_pvalid;
    logic                    r_porg;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DOT_W-1:0] r_org;
    logic signed [DOT_W-1:0] r_dir;

    logic signed [T_W-1:0]   r_lo;
    logic signed [T_W-1:0]   r_hi;
    logic signed [T_W-1:0]   r_tn;
    logic                    r_miss;
    logic                    r_phase;

    logic                    r_have;
    logic [ID_BITS-1:0]      r_best_box;
    logic [ENTRY_W-1:0]      r_best;

    logic                    r_out_valid;
    t_result                 r_out;

    logic signed [C-1:0]      w_ax   [3][3];
    logic [C-1:0]             w_hs   [3];
    logic signed [DIFF_W-1:0] w_rel  [3];
    logic signed [DIFF_W-1:0] w_delta[3];
    logic [1:0]               w_k;
    logic signed [DIFF_W-1:0] w_a;
    logic signed [C-1:0]      w_b;
    logic [HEXT_W-1:0]        w_ext_u;
    logic signed [EXTS_W:0]   w_ext;
    logic signed [NUM_W-1:0]  w_num;
    logic                     w_outside;
    logic                     w_div_done;
    logic signed [T_W-1:0]    w_t;
    logic signed [T_W-1:0]    w_tmin;
    logic signed [T_W-1:0]    w_tmax;
    logic signed [T_W-1:0]    n_lo;
    logic signed [T_W-1:0]    n_hi;
    logic [ID_BITS-1:0]       w_id;
    logic [ENTRY_W-1:0]       w_entry;
    logic                     w_hit;
    logic                     w_better;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_ax[0][k] = $signed(r_item.axis_one[k*C +: C]);
            w_ax[1][k] = $signed(r_item.axis_two[k*C +: C]);
            w_ax[2][k] = $signed(r_item.axis_three[k*C +: C]);
            w_hs[k]    = r_item.half_size[k*C +: C];
            w_rel[k]   = DIFF_W'($signed(r_start[k*C +: C]))
                       - DIFF_W'($signed(r_item.box_center[k*C +: C]));
            w_delta[k] = DIFF_W'($signed(r_end[k*C +: C]))
                       - DIFF_W'($signed(r_start[k*C +: C]));
        end
        w_k = (i_cmd.term < 3'd3) ? i_cmd.term[1:0] : 2'(i_cmd.term - 3'd3);
        w_a = (i_cmd.term < 3'd3) ? w_rel[w_k] : w_delta[w_k];
        w_b = w_ax[i_cmd.axis][w_k];

        w_ext_u = HEXT_W'(w_hs[i_cmd.axis]) + HEXT_W'(r_infl);
        w_ext   = $signed({1'b0, w_ext_u, {(C-2){1'b0}}});
        w_num   = i_cmd.div_hi ? (NUM_W'(w_ext) - NUM_W'(r_org))
                               : (-NUM_W'(w_ext) - NUM_W'(r_org));
        w_outside = (NUM_W'(r_org) > NUM_W'(w_ext)) || (NUM_W'(r_org) < -NUM_W'(w_ext));

        w_tmin = (r_tn < w_t) ? r_tn : w_t;
        w_tmax = (r_tn < w_t) ? w_t : r_tn;
        n_lo   = (w_tmin > r_lo) ? w_tmin : r_lo;
        n_hi   = (w_tmax < r_hi) ? w_tmax : r_hi;

        w_id     = ID_BITS'(r_item.box_id);
        w_entry  = r_lo[ENTRY_W-1:0];
        w_hit    = (w_id != ID_BITS'(r_skip)) && !r_miss && !r_hi[T_W-1] && (r_lo < T_ONE);
        w_better = !r_have || (w_entry < r_best) || ((w_entry == r_best) && (w_id < r_best_box));
    end

    sbos_div #(
        .NUM_W(NUM_W),
        .DEN_W(DOT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (r_dir),
        .o_done  (w_div_done),
        .o_t     (w_t)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_end       <= '0;
            r_infl      <= '0;
            r_skip      <= '0;
            r_pvalid    <= 1'b0;
            r_miss      <= 1'b0;
            r_have      <= 1'b0;
            r_best_box  <= '0;
            r_best      <= ONE_Q16;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SEG_START: r_start <= i_cfg_data;
                    CFG_SEG_END:   r_end   <= i_cfg_data;
                    CFG_INFLATION: r_infl  <= i_cfg_data[INFL_W-1:0];
                    CFG_SKIP_ID:   r_skip  <= i_cfg_data[ID_W-1:0];
                endcase
            end

            if (i_take) begin
                r_item <= i_box;
                r_lo   <= T_ZERO;
                r_hi   <= T_ONE;
                r_miss <= 1'b0;
            end

            r_pvalid <= i_cmd.mul;
            if (i_cmd.mul) begin
                r_prod <= w_a * w_b;
                r_porg <= (i_cmd.term < 3'd3);
            end
            if (i_cmd.acc_clr) begin
                r_org <= '0;
                r_dir <= '0;
            end else if (r_pvalid) begin
                if (r_porg) begin
                    r_org <= r_org + DOT_W'(r_prod);
                end else begin
                    r_dir <= r_dir + DOT_W'(r_prod);
                end
            end

            if (i_cmd.div_start) begin
                r_phase <= i_cmd.div_hi;
            end
            if (w_div_done && !r_phase) begin
                r_tn <= w_t;
            end

            if (i_cmd.par_chk && w_outside) begin
                r_miss <= 1'b1;
            end
            if (i_cmd.slab_upd) begin
                r_lo <= n_lo;
                r_hi <= n_hi;
                if (n_lo > n_hi) begin
                    r_miss <= 1'b1;
                end
            end

            if (i_cmd.commit && w_hit && w_better) begin
                r_have     <= 1'b1;
                r_best     <= w_entry;
                r_best_box <= w_id;
            end

            if (o_res_valid && !i_res_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid       <= 1'b1;
                r_out.blocked     <= r_have;
                r_out.blocker_id  <= r_have ? ID_W'(r_best_box) : '0;
                r_out.entry_param <= r_have ? r_best : ONE_Q16;
                r_have            <= 1'b0;
                r_best            <= ONE_Q16;
                r_best_box        <= '0;
            end
        end
    end

    assign o_stat.dir_zero = (r_dir == '0);
    assign o_stat.div_done = w_div_done;
    assign o_stat.last     = r_item.last_box;
    assign o_stat.out_free = !r_out_valid;
    assign o_res_valid     = r_out_valid;
    assign o_res           = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> (r_dir != '0))
        else $error("division started on a parallel axis");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_out_valid)
        else $error("result emitted over a pending result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_lo[T_W-1] && !i_cmd.slab_upd))
        else $error("commit with negative entry or during slab update");

endmodule

// ----- rtl/sbos_ctrl.sv -----
module sbos_ctrl import sbos_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_dp_stat i_stat,
    output logic     o_busy,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DRAIN,
        S_CHECK,
        S_WAIT_N,
        S_WAIT_F,
        S_NEXT,
        S_FINAL,
        S_EMIT
    } t_state;

    t_state     r_state;
    logic [2:0] r_cnt;
    logic [1:0] r_axis;
    t_dp_cmd    r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_axis  <= '0;
            r_cmd   <= '0;
        end else begin
            r_cmd      <= '0;
            r_cmd.axis <= r_axis;
            unique case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        r_state <= S_MUL;
                        r_cnt   <= '0;
                        r_axis  <= '0;
                    end
                end
                S_MUL: begin
                    r_cmd.mul     <= 1'b1;
                    r_cmd.term    <= r_cnt;
                    r_cmd.acc_clr <= (r_cnt == '0);
                    if (r_cnt == TERM_LAST) begin
                        r_state <= S_DRAIN;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (r_cnt == 3'd1) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_CHECK: begin
                    if (i_stat.dir_zero) begin
                        r_cmd.par_chk <= 1'b1;
                        r_state       <= S_NEXT;
                    end else begin
                        r_cmd.div_start <= 1'b1;
                        r_state         <= S_WAIT_N;
                    end
                end
                S_WAIT_N: begin
                    if (i_stat.div_done) begin
                        r_cmd.div_start <= 1'b1;
                        r_cmd.div_hi    <= 1'b1;
                        r_state         <= S_WAIT_F;
                    end
                end
                S_WAIT_F: begin
                    if (i_stat.div_done) begin
                        r_cmd.slab_upd <= 1'b1;
                        r_state        <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_axis == AXIS_LAST) begin
                        r_cmd.commit <= 1'b1;
                        r_state      <= S_FINAL;
                    end else begin
                        r_axis  <= r_axis + 1'b1;
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_FINAL: begin
                    r_state <= i_stat.last ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (i_stat.out_free) begin
                        r_cmd.emit <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE) || !i_rst_n;
    assign o_cmd  = r_cmd;

endmodule

// ----- rtl/segment_box_occlusion_search.sv -----
// Channel   Direction  Handshake                 Payload
// box       in         i_box_valid / o_box_stall  i_box (t_box), one oriented box
// result    out        o_res_valid / i_res_stall  o_res (t_result), one per query
// config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One pass through the shared divider is start, overflow check, 18 quotient
// steps and done. A last box adds the result hand-off. An axis whose
// direction is zero skips both divisions; an overflowing bound ends its
// division early. Reset is synchronous and active low; it clears the
// registers and the query. The box side stalls while a box is being worked
// on. A finished result waits in the output register, and a last box stalls
// only if that register is full.
module segment_box_occlusion_search import sbos_pkg::*; #(
    parameter int ID_BITS    = 16,
    parameter int COORD_BITS = 21
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_box_valid,
    output logic               o_box_stall,
    input  t_box               i_box,
    output logic               o_res_valid,
    input  logic               i_res_stall,
    output t_result            o_res,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [FIELD_W-1:0] i_cfg_data
);

    // Controller sequences each box: six multiply terms per axis on one shared
    // multiplier, then the near and far slab bounds through the divider.
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_busy;
    logic     w_accept;

    // A box transaction completes when valid is high and the block is free.
    assign w_accept    = i_box_valid && !w_busy;
    assign o_box_stall = w_busy;

    sbos_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_stat   (w_stat),
        .o_busy   (w_busy),
        .o_cmd    (w_cmd)
    );

    // Datapath holds the configuration, the box, the dot-product accumulators,
    // the slab interval, the best hit of the query and the result register.
    sbos_dp #(
        .ID_BITS    (ID_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_accept),
        .i_box       (i_box),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_res       (o_res)
    );

endmodule

// ----- tb/tb_segment_box_occlusion_search.sv -----
`timescale 1ns / 100ps

module tb_segment_box_occlusion_search;
    import sbos_pkg::*;

    localparam int STALL_LIMIT = 20000; // idle cycles before the run is declared hung
    localparam int SETTLE      = 250;   // longer than one box in flight
    localparam int UNIT        = 524288; // 1.0 in Q1.19
    localparam int DIAG        = 370728; // about 0.7071 in Q1.19

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_box_valid = 1'b0;
    logic               o_box_stall;
    t_box               i_box = '0;
    logic               o_res_valid;
    logic               i_res_stall = 1'b0;
    t_result            o_res;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [FIELD_W-1:0] i_cfg_data = '0;

    segment_box_occlusion_search DUT (.*);

    always #5 i_clk = ~i_clk;

    // Shadow copy of the configuration registers and of the running query.
    logic [FIELD_W-1:0] seg_start_q, seg_end_q;
    logic [INFL_W-1:0]  inflation_q;
    logic [ID_W-1:0]    skip_id_q;
    int unsigned        nearest_entry;
    logic [ID_W-1:0]    nearest_id;
    bit                 query_has_hit;

    // Integer copies of the segment end points, used to place boxes along the path.
    int seg_x0, seg_y0, seg_z0, seg_x1, seg_y1, seg_z1;

    t_result     verdict_q[$];
    bit          failed = 1'b0;
    bit          quiet = 1'b0;
    int          queries_seen = 0;
    int          blocked_seen = 0;
    int          idle_cycles = 0;

    function automatic logic [FIELD_W-1:0] pack3(int x, int y, int z);
        logic [20:0] a, b, c;
        a = x[20:0];
        b = y[20:0];
        c = z[20:0];
        return {c, b, a};
    endfunction

    function automatic longint coord_s(logic [FIELD_W-1:0] p, int k);
        logic signed [20:0] v;
        v = p[k*21 +: 21];
        return longint'(v);
    endfunction

    function automatic longint coord_u(logic [FIELD_W-1:0] p, int k);
        return longint'({43'd0, p[k*21 +: 21]});
    endfunction

    // Division rounded toward minus infinity.
    function automatic longint floor_quot(longint n, longint d);
        longint q, r;
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        q = n / d;
        r = n % d;
        if (r != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    // Slab test of one oriented box against the inflated segment; returns 1 on a hit.
    function automatic bit box_hit(t_box b, output longint entry);
        longint delta[3], rel[3];
        longint lo, hi, org, dir, ext, tn, tf, tmp;
        logic [FIELD_W-1:0] ax;
        lo = 0;
        hi = 65536;
        entry = 0;
        for (int k = 0; k < 3; k++) begin
            delta[k] = coord_s(seg_end_q, k) - coord_s(seg_start_q, k);
            rel[k]   = coord_s(seg_start_q, k) - coord_s(b.box_center, k);
        end
        for (int k = 0; k < 3; k++) begin
            ax = (k == 0) ? b.axis_one : (k == 1) ? b.axis_two : b.axis_three;
            org = rel[0] * coord_s(ax, 0) + rel[1] * coord_s(ax, 1) + rel[2] * coord_s(ax, 2);
            dir = delta[0] * coord_s(ax, 0) + delta[1] * coord_s(ax, 1)
                + delta[2] * coord_s(ax, 2);
            ext = (coord_u(b.half_size, k) + longint'(inflation_q)) * 64'sd524288;
            if (dir == 0) begin
                // A parallel axis only rejects; it never narrows the interval.
                if (org < -ext || org > ext) return 1'b0;
                continue;
            end
            tn = floor_quot((-ext - org) * 65536, dir);
            tf = floor_quot((ext - org) * 65536, dir);
            if (tn > tf) begin
                tmp = tn;
                tn = tf;
                tf = tmp;
            end
            if (tn > lo) lo = tn;
            if (tf < hi) hi = tf;
            if (lo > hi) return 1'b0;
        end
        if (hi < 0 || lo > 65536) return 1'b0;
        if (lo < 0) lo = 0;
        if (lo > 65536) lo = 65536;
        entry = lo;
        return 1'b1;
    endfunction

    // Folds one accepted box into the running query and queues the verdict on the last box.
    task automatic track_box(t_box b);
        longint entry;
        t_result r;
        if (b.box_id != skip_id_q && box_hit(b, entry) && entry < 65536) begin
            if (!query_has_hit || entry < nearest_entry
                || (entry == nearest_entry && b.box_id < nearest_id)) begin
                nearest_entry = int'(entry);
                nearest_id    = b.box_id;
                query_has_hit = 1'b1;
            end
        end
        if (b.last_box) begin
            r.blocked     = query_has_hit;
            r.blocker_id  = query_has_hit ? nearest_id : '0;
            r.entry_param = query_has_hit ? nearest_entry[16:0] : ONE_Q16;
            verdict_q.push_back(r);
            nearest_entry = 65536;
            nearest_id    = '0;
            query_has_hit = 1'b0;
        end
    endtask

    // Offers one box, with an occasional idle gap first, and waits until it is taken.
    task automatic send_box(t_box b);
        while (!quiet && $urandom_range(99) < 9) begin
            i_box_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_box_valid <= 1'b1;
        i_box       <= b;
        @(posedge i_clk);
        while (o_box_stall) @(posedge i_clk);
        track_box(b);
    endtask

    task automatic end_burst();
        i_box_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        // Boxes without a verdict may still be in the datapath.
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [FIELD_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SEG_START: seg_start_q = data;
            CFG_SEG_END:   seg_end_q = data;
            CFG_INFLATION: inflation_q = data[INFL_W-1:0];
            default:       skip_id_q = data[ID_W-1:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_path(int x0, int y0, int z0, int x1, int y1, int z1,
                            int unsigned grow, int unsigned skip);
        seg_x0 = x0; seg_y0 = y0; seg_z0 = z0;
        seg_x1 = x1; seg_y1 = y1; seg_z1 = z1;
        cfg_write(CFG_SEG_START, pack3(x0, y0, z0));
        cfg_write(CFG_SEG_END, pack3(x1, y1, z1));
        cfg_write(CFG_INFLATION, {43'd0, grow[19:0]});
        cfg_write(CFG_SKIP_ID, {47'd0, skip[15:0]});
    endtask

    function automatic t_box aligned_box(int id, int cx, int cy, int cz, int h, bit last);
        t_box b;
        b.box_id     = id[15:0];
        b.box_center = pack3(cx, cy, cz);
        b.axis_one   = pack3(UNIT - 1, 0, 0);
        b.axis_two   = pack3(0, UNIT - 1, 0);
        b.axis_three = pack3(0, 0, UNIT - 1);
        b.half_size  = pack3(h, h, h);
        b.last_box   = last;
        return b;
    endfunction

    function automatic logic [FIELD_W-1:0] rand63();
        return FIELD_W'({$urandom, $urandom});
    endfunction

    // Most boxes sit near the path, mostly with a proper orientation; the rest are raw noise.
    function automatic t_box random_box(int unsigned skip, bit last);
        t_box b;
        int f, s, p, u;
        u = UNIT - 1;
        if ($urandom_range(99) < 15) begin
            b = {16'($urandom), rand63(), rand63(), rand63(), rand63(), rand63(), 1'b0};
        end else begin
            f = $urandom_range(256);
            b.box_center = pack3(
                seg_x0 + (seg_x1 - seg_x0) * f / 256 + $signed($urandom_range(600)) - 300,
                seg_y0 + (seg_y1 - seg_y0) * f / 256 + $signed($urandom_range(600)) - 300,
                seg_z0 + (seg_z1 - seg_z0) * f / 256 + $signed($urandom_range(600)) - 300);
            s = $urandom_range(1) ? 1 : -1;
            p = $urandom_range(3);
            case (p)
                0: begin
                    b.axis_one = pack3(s * u, 0, 0);
                    b.axis_two = pack3(0, u, 0);
                    b.axis_three = pack3(0, 0, s * u);
                end
                1: begin
                    b.axis_one = pack3(0, s * u, 0);
                    b.axis_two = pack3(0, 0, u);
                    b.axis_three = pack3(s * u, 0, 0);
                end
                2: begin
                    b.axis_one = pack3(DIAG, s * DIAG, 0);
                    b.axis_two = pack3(-s * DIAG, DIAG, 0);
                    b.axis_three = pack3(0, 0, u);
                end
                default: begin
                    b.axis_one = rand63();
                    b.axis_two = rand63();
                    b.axis_three = rand63();
                end
            endcase
            b.half_size = pack3($urandom_range(400), $urandom_range(400), $urandom_range(400));
            // Small ids make ties and skipped boxes common.
            b.box_id = ($urandom_range(3) == 0) ? skip[15:0] : 16'($urandom_range(12));
        end
        b.last_box = last;
        return b;
    endfunction

    // Result side: random stall, then every accepted verdict is checked in order.
    always @(posedge i_clk) begin
        i_res_stall <= quiet ? 1'b0 : ($urandom_range(99) < 9);
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, o_res);
                failed = 1'b1;
            end else begin
                t_result want;
                want = verdict_q.pop_front();
                queries_seen++;
                if (want.blocked) blocked_seen++;
                if (o_res.blocked !== want.blocked) begin
                    $display("%0t: blocked expected %0d actual %0d", $realtime,
                             want.blocked, o_res.blocked);
                    failed = 1'b1;
                end
                if (o_res.blocker_id !== want.blocker_id) begin
                    $display("%0t: blocker_id expected %0d actual %0d", $realtime,
                             want.blocker_id, o_res.blocker_id);
                    failed = 1'b1;
                end
                if (o_res.entry_param !== want.entry_param) begin
                    $display("%0t: entry_param expected %0d actual %0d", $realtime,
                             want.entry_param, o_res.entry_param);
                    failed = 1'b1;
                end
            end
        end
    end

    // Hang detection: count cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((i_box_valid && !o_box_stall) || (o_res_valid && !i_res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
            $display("[segment_box_occlusion_search] ERROR");
            $finish;
        end
    end

    // Hand-placed cases: a segment on the x axis, a zero-length one and field extremes.
    task automatic test_directed();
        t_box b;
        set_path(0, 0, 0, 1600, 0, 0, 16, 7);
        // Two equal hits: the lower id must win; the skipped id is ignored even
        // though it is nearer.
        send_box(aligned_box(5, 800, 0, 0, 80, 0));
        send_box(aligned_box(3, 800, 0, 0, 80, 0));
        send_box(aligned_box(7, 300, 0, 0, 80, 0));
        send_box(aligned_box(9, 0, 5000, 0, 80, 1));
        // A box touching the far end enters at exactly one and is not a blocker.
        send_box(aligned_box(4, 1696, 0, 0, 80, 1));
        // Segment starting inside a box: entry clamps to zero.
        send_box(aligned_box(0, 0, 0, 0, 40, 1));
        // Zero-length segment: every axis is parallel.
        end_burst();
        set_path(100, 100, 100, 100, 100, 100, 0, 16'hFFFF);
        send_box(aligned_box(16'hFFFF, 100, 100, 100, 10, 0));
        send_box(aligned_box(2, 100, 100, 120, 10, 0));
        send_box(aligned_box(1, 100, 100, 200, 10, 1));
        // Field extremes: all zeros and all ones.
        send_box('0);
        b = '1;
        send_box(b);
        b = '0;
        b.last_box = 1'b1;
        send_box(b);
        end_burst();
        set_path(-1048576, -1048576, -1048576, 1048575, 1048575, 1048575, 20'hFFFFF, 0);
        send_box(aligned_box(0, 0, 0, 0, 0, 0));
        b = '1;
        b.box_id = 16'h1234;
        send_box(b);
        send_box(aligned_box(16'hFFFF, -1048576, 1048575, 0, 2097151, 1));
        end_burst();
    endtask

    // Queries of one to six boxes under one configuration.
    task automatic run_queries(int n_queries, int unsigned skip);
        int len;
        for (int q = 0; q < n_queries; q++) begin
            len = $urandom_range(6, 1);
            for (int i = 0; i < len; i++) send_box(random_box(skip, i == len - 1));
        end
        end_burst();
    endtask

    task automatic test_random_paths();
        int unsigned skip;
        for (int p = 0; p < 10; p++) begin
            skip = (p == 0) ? 0 : (p == 1) ? 16'hFFFF : $urandom_range(12);
            set_path($urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                     $urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                     $urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                     (p == 2) ? 20'hFFFFF : $urandom_range(100), skip);
            // Segments lying along one axis produce parallel slabs.
            if (p == 3) set_path(-2000, 50, 50, 2000, 50, 50, 8, skip);
            run_queries(40, skip);
        end
        // Raw register values, far outside the usual range.
        cfg_write(CFG_SEG_START, rand63());
        cfg_write(CFG_SEG_END, rand63());
        run_queries(20, skip_id_q);
    endtask

    // No idling on either side; in the closing queries the sender also waits out each verdict.
    task automatic test_back_to_back();
        quiet = 1'b1;
        set_path(-3000, 200, -100, 3000, -200, 100, 24, 5);
        run_queries(60, 5);
        for (int q = 0; q < 10; q++) begin
            send_box(random_box(5, 0));
            send_box(random_box(5, 1));
            end_burst();
        end
        quiet = 1'b0;
    endtask

    initial begin
        seg_start_q   = '0;
        seg_end_q     = '0;
        inflation_q   = '0;
        skip_id_q     = '0;
        nearest_entry = 65536;
        nearest_id    = '0;
        query_has_hit = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_paths();
        test_back_to_back();
        $display("Checked %0d query verdicts, %0d of them blocked, over random and directed paths.",
                 queries_seen, blocked_seen);
        if (!failed && verdict_q.size() == 0) begin
            $display("[segment_box_occlusion_search] OK");
        end else begin
            $display("[segment_box_occlusion_search] ERROR");
        end
        $finish;
    end

endmodule
